// ----- rtl/clrs_pkg.sv -----
// shared types and constants for the character lcd request sequencer
// no dependencies
`timescale 1ns / 1ps
package clrs_pkg;
    localparam logic [3:0] OP_TICK = 4'd0;
    localparam logic [3:0] OP_INIT = 4'd1;
    localparam logic [3:0] OP_CHAR = 4'd2;
    localparam logic [3:0] OP_NUM = 4'd3;
    localparam logic [3:0] OP_CLEAR = 4'd4;
    localparam logic [3:0] OP_POS = 4'd5;
    localparam logic [3:0] OP_SHIFT = 4'd6;
    localparam logic [3:0] OP_CUR_OFF = 4'd7;
    localparam logic [3:0] OP_CUR_ON = 4'd8;

    localparam logic [2:0] K_CHAR = 3'd0;
    localparam logic [2:0] K_NUM = 3'd1;
    localparam logic [2:0] K_CLEAR = 3'd2;
    localparam logic [2:0] K_POS = 3'd3;
    localparam logic [2:0] K_SHIFT = 3'd4;
    localparam logic [2:0] K_CUR_OFF = 3'd5;
    localparam logic [2:0] K_CUR_ON = 3'd6;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_BAD_POS = 2'd2;

    localparam logic [7:0] CMD_FUNC = 8'h38;
    localparam logic [7:0] CMD_DISP_ON = 8'h0F;
    localparam logic [7:0] CMD_CLEAR = 8'h01;
    localparam logic [7:0] CMD_ENTRY = 8'h06;
    localparam logic [7:0] CMD_CUR_OFF = 8'h0C;
    localparam logic [7:0] CMD_CUR_ON = 8'h0E;
    localparam logic [7:0] CMD_DDRAM = 8'h80;
    localparam logic [7:0] ROW1_OFS = 8'h40;
    localparam logic [7:0] ASCII_ZERO = 8'h30;

    // classified transaction from front to back
    typedef struct packed {
        logic [3:0]  opcode;
        logic [2:0]  kind;
        logic [15:0] arg;
        logic [1:0]  flags;
        logic        notify;
    } t_req;

    function automatic logic [7:0] init_cmd(input logic [1:0] k);
        logic [7:0] c;
        case (k)
            2'd0: c = CMD_FUNC;
            2'd1: c = CMD_DISP_ON;
            2'd2: c = CMD_CLEAR;
            default: c = CMD_ENTRY;
        endcase
        return c;
    endfunction
endpackage

// ----- rtl/clrs_front.sv -----
// front: takes a transaction and forwards a classified request
// depends on clrs_pkg
`timescale 1ns / 1ps
module clrs_front
    import clrs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_back_ready,
    input  logic [3:0]  i_opcode,
    input  logic [7:0]  i_char_code,
    input  logic        i_last_char,
    input  logic [15:0] i_number_value,
    input  logic [7:0]  i_row,
    input  logic [7:0]  i_column,
    input  logic        i_notify,
    output logic        o_busy,
    output logic        o_req_valid,
    output t_req        o_req
);
    logic r_valid;
    t_req r_req;
    t_req n_req;

    assign o_busy = r_valid;
    assign o_req_valid = r_valid;
    assign o_req = r_req;

    always_comb begin
        n_req.opcode = i_opcode;
        n_req.notify = i_notify;
        n_req.kind = K_CHAR;
        n_req.arg = {8'd0, i_char_code};
        n_req.flags = {1'b0, i_notify};
        unique case (i_opcode)
            OP_CHAR: begin
                n_req.flags = {i_last_char, i_notify};
            end
            OP_NUM: begin
                n_req.kind = K_NUM;
                n_req.arg = i_number_value;
            end
            OP_CLEAR: begin
                n_req.kind = K_CLEAR;
            end
            OP_POS: begin
                n_req.kind = K_POS;
                n_req.arg = {i_row, i_column};
            end
            OP_SHIFT: begin
                n_req.kind = K_SHIFT;
            end
            OP_CUR_OFF: begin
                n_req.kind = K_CUR_OFF;
            end
            OP_CUR_ON: begin
                n_req.kind = K_CUR_ON;
            end
            default: begin
                n_req.kind = K_CHAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_start && !r_valid) begin
            r_valid <= 1'b1;
        end else if (r_valid && i_back_ready) begin
            r_valid <= 1'b0;
        end
        if (i_start && !r_valid) begin
            r_req <= n_req;
        end
    end
endmodule

// ----- rtl/clrs_back.sv -----
// back: slot ring, init sequencer, enable pulses and decimal digit split
// depends on clrs_pkg
`timescale 1ns / 1ps
module clrs_back
    import clrs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 128,
    parameter int MAX_DIGITS = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  t_req        i_req,
    input  logic [7:0]  i_power_on_ticks,
    output logic        o_ready,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic        o_reg_select,
    output logic        o_read_write,
    output logic [7:0]  o_data_bus,
    output logic        o_enable,
    output logic        o_done_notice,
    output logic        o_init_done
);
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int DW = $clog2(MAX_DIGITS + 1);
    localparam int SW = 4 * MAX_DIGITS;

    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_INIT = 2'd1;
    localparam logic [1:0] MODE_OPER = 2'd2;

    // phase of the sequencer for one transaction
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_READ = 3'd1;
    localparam logic [2:0] PH_EXEC = 3'd2;
    localparam logic [2:0] PH_SPLIT = 3'd3;
    localparam logic [2:0] PH_CLEAR = 3'd4;

    logic [2:0] r_ph;
    logic [1:0] r_mode;
    logic [2:0] r_init_step;
    logic [7:0] r_wait;
    logic       r_phase;
    logic [QW-1:0] r_wr;
    logic [QW-1:0] r_rd;
    logic [QUEUE_DEPTH-1:0] r_busy_bits;
    logic [DW-1:0] r_cursor;
    logic       r_init_notify;
    logic [10:0] r_pins;

    // slot memory
    logic [20:0] r_mem [QUEUE_DEPTH];
    logic [20:0] r_head;
    logic        r_mem_we;
    logic [QW-1:0] r_mem_wa;
    logic [20:0] r_mem_wd;

    // digit split
    logic [15:0] r_rem;
    logic [SW-1:0] r_digits;
    logic [DW-1:0] r_ndig;
    logic [DW-1:0] r_k;

    logic        r_valid;
    logic [1:0]  r_status;
    logic        r_done;
    logic        r_idone;

    assign o_ready = (r_ph == PH_IDLE) && !r_mem_we;
    assign o_valid = r_valid;
    assign o_status = r_status;
    assign o_reg_select = r_pins[0];
    assign o_read_write = r_pins[1];
    assign o_data_bus = r_pins[9:2];
    assign o_enable = r_pins[10];
    assign o_done_notice = r_done;
    assign o_init_done = r_idone;

    always_ff @(posedge i_clk) begin
        if (r_mem_we) begin
            r_mem[r_mem_wa] <= r_mem_wd;
        end
        r_head <= r_mem[r_rd];
    end

    logic [2:0]  h_kind;
    logic [15:0] h_arg;
    logic [1:0]  h_flags;
    logic [7:0]  pos_addr;
    logic        take;
    logic [15:0] q10;
    logic [3:0]  r10;
    logic [31:0] prod;
    logic [3:0]  cur_dig;
    logic [DW-1:0] didx;

    assign h_kind = r_head[20:18];
    assign h_arg = r_head[17:2];
    assign h_flags = r_head[1:0];
    assign pos_addr = h_arg[7:0] + (h_arg[8] ? ROW1_OFS : 8'd0) + CMD_DDRAM;
    assign take = i_req_valid && o_ready;
    // divide by ten through reciprocal
    assign prod = {16'd0, r_rem} * 32'd52429;
    assign q10 = {3'd0, prod[31:19]};
    assign r10 = 4'(r_rem - 16'(q10 * 16'd10));
    assign didx = DW'(r_ndig - 1'b1 - r_cursor);
    assign cur_dig = r_digits[4*didx +: 4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_IDLE;
            r_mode <= MODE_OFF;
            r_init_step <= 3'd0;
            r_wait <= 8'd0;
            r_phase <= 1'b0;
            r_wr <= '0;
            r_rd <= '0;
            r_busy_bits <= '0;
            r_cursor <= '0;
            r_init_notify <= 1'b0;
            r_pins <= '0;
            r_valid <= 1'b0;
            r_done <= 1'b0;
            r_idone <= 1'b0;
            r_status <= ST_OK;
            r_mem_we <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            r_done <= 1'b0;
            r_idone <= 1'b0;
            r_status <= ST_OK;
            r_mem_we <= 1'b0;
            unique case (r_ph)
                PH_IDLE: begin
                    if (take) begin
                        case (i_req.opcode)
                            OP_TICK: begin
                                if (r_mode == MODE_OPER && r_busy_bits[r_rd]) begin
                                    r_ph <= PH_READ;
                                end else begin
                                    r_valid <= 1'b1;
                                    if (r_mode == MODE_INIT) begin
                                        if (r_init_step == 3'd0) begin
                                            if (r_wait != 8'hFF) begin
                                                r_wait <= r_wait + 8'd1;
                                            end
                                            if ((r_wait == 8'hFF ? r_wait : r_wait + 8'd1)
                                                >= i_power_on_ticks) begin
                                                r_init_step <= 3'd1;
                                            end
                                        end else if (r_init_step <= 3'd4) begin
                                            if (!r_phase) begin
                                                r_pins <= {1'b1,
                                                    init_cmd(2'(r_init_step - 3'd1)),
                                                    1'b0, 1'b0};
                                                r_phase <= 1'b1;
                                            end else begin
                                                r_pins[10] <= 1'b0;
                                                r_phase <= 1'b0;
                                                r_init_step <= r_init_step + 3'd1;
                                            end
                                        end else begin
                                            r_mode <= MODE_OPER;
                                            r_idone <= r_init_notify;
                                        end
                                    end
                                end
                            end
                            OP_INIT: begin
                                r_busy_bits <= '0;
                                r_mode <= MODE_INIT;
                                r_init_step <= 3'd0;
                                r_wait <= 8'd0;
                                r_phase <= 1'b0;
                                r_cursor <= '0;
                                r_init_notify <= i_req.notify;
                                r_valid <= 1'b1;
                            end
                            OP_CHAR, OP_NUM, OP_CLEAR, OP_POS, OP_SHIFT,
                            OP_CUR_OFF, OP_CUR_ON: begin
                                r_valid <= 1'b1;
                                if (i_req.opcode == OP_POS &&
                                    (i_req.arg[15:8] > 8'd1 || i_req.arg[7:0] > 8'd15)) begin
                                    r_status <= ST_BAD_POS;
                                end else begin
                                    if (r_busy_bits[r_wr]) begin
                                        r_status <= ST_BUSY;
                                    end else begin
                                        r_busy_bits[r_wr] <= 1'b1;
                                        r_mem_we <= 1'b1;
                                        r_mem_wa <= r_wr;
                                        r_mem_wd <= {i_req.kind,
                                            (i_req.kind == K_POS) ?
                                                {7'd0, i_req.arg[8], i_req.arg[7:0]} :
                                                i_req.arg, i_req.flags};
                                    end
                                    r_wr <= (r_wr == QW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
                                end
                            end
                            default: begin
                                r_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                PH_READ: begin
                    r_ph <= PH_EXEC;
                    if (h_kind == K_NUM && !r_phase) begin
                        r_rem <= h_arg;
                        r_k <= '0;
                        r_ndig <= DW'(1);
                        r_ph <= PH_SPLIT;
                    end
                end
                PH_SPLIT: begin
                    r_digits[4*r_k +: 4] <= r10;
                    r_rem <= q10;
                    if (r_k != '0 && r_rem != 16'd0) begin
                        r_ndig <= r_k + DW'(1);
                    end
                    if (r_k == DW'(MAX_DIGITS - 1)) begin
                        r_ph <= PH_CLEAR;
                    end else begin
                        r_k <= r_k + DW'(1);
                    end
                end
                PH_CLEAR: begin
                    if (r_cursor >= r_ndig) begin
                        r_cursor <= '0;
                    end
                    r_ph <= PH_EXEC;
                end
                PH_EXEC: begin
                    r_ph <= PH_IDLE;
                    r_valid <= 1'b1;
                    if (!r_phase) begin
                        r_phase <= 1'b1;
                        case (h_kind)
                            K_CHAR: r_pins <= {1'b1, h_arg[7:0], 1'b0, 1'b1};
                            K_NUM: r_pins <= {1'b1, ASCII_ZERO + {4'd0, cur_dig}, 1'b0, 1'b1};
                            K_CLEAR: r_pins <= {1'b1, CMD_CLEAR, 2'b00};
                            K_POS: r_pins <= {1'b1, pos_addr, 2'b00};
                            K_SHIFT: r_pins <= {1'b1, h_arg[7:0], 2'b00};
                            K_CUR_OFF: r_pins <= {1'b1, CMD_CUR_OFF, 2'b00};
                            K_CUR_ON: r_pins <= {1'b1, CMD_CUR_ON, 2'b00};
                            default: begin
                                r_phase <= 1'b0;
                                r_busy_bits[r_rd] <= 1'b0;
                                r_rd <= (r_rd == QW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
                            end
                        endcase
                    end else begin
                        r_pins[10] <= 1'b0;
                        r_phase <= 1'b0;
                        if (h_kind != K_NUM || r_cursor + DW'(1) >= r_ndig) begin
                            r_busy_bits[r_rd] <= 1'b0;
                            r_rd <= (r_rd == QW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
                            if (h_kind == K_NUM) begin
                                r_cursor <= '0;
                            end
                            case (h_kind)
                                K_CHAR: r_done <= &h_flags;
                                K_NUM, K_POS: r_done <= h_flags[0];
                                default: r_done <= 1'b0;
                            endcase
                        end else begin
                            r_cursor <= r_cursor + DW'(1);
                        end
                    end
                end
                default: begin
                    r_ph <= PH_IDLE;
                end
            endcase
        end
    end

    a_one_notice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_done && r_idone)) else $error("both notices at once");
    a_notice_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done || r_idone) |-> r_valid) else $error("notice without result");
    a_rw_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pins[1]) else $error("rw driven high");
    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= DW'(MAX_DIGITS)) else $error("digit cursor out of range");
endmodule

// ----- rtl/char_lcd_request_sequencer.sv -----
// top level of the character lcd request sequencer
// depends on clrs_pkg, clrs_front, clrs_back
//
// channel | handshake                  | payload
// request | start / busy               | i_opcode .. i_notify
// result  | o_valid strobe, no stall   | o_status .. o_init_done
// config  | i_cfg_we                   | i_cfg_data (power_on_ticks)
//
// accept loads the front request register; the back takes it and registers the result strobe
// a tick serving the head passes the slot read and the exec phase first; a number high phase
// adds the digit split (one digit a cycle) and a cursor check between the slot read and exec
// busy stays high from accept through the result strobe cycle
// reset is synchronous, active low; slot contents need no clearing
`timescale 1ns / 1ps
module char_lcd_request_sequencer
    import clrs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 128,
    parameter int MAX_DIGITS = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic [3:0]  i_opcode,
    input  logic [7:0]  i_char_code,
    input  logic        i_last_char,
    input  logic [15:0] i_number_value,
    input  logic [7:0]  i_row,
    input  logic [7:0]  i_column,
    input  logic        i_notify,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic        o_reg_select,
    output logic        o_read_write,
    output logic [7:0]  o_data_bus,
    output logic        o_enable,
    output logic        o_done_notice,
    output logic        o_init_done
);
    logic [7:0] r_power_on_ticks;
    logic       fr_busy;
    logic       req_valid;
    logic       back_ready;
    logic       r_pending;
    t_req       req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power_on_ticks <= 8'd15;
            r_pending <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_power_on_ticks <= i_cfg_data;
            end
            if (start && !busy) begin
                r_pending <= 1'b1;
            end else if (o_valid) begin
                r_pending <= 1'b0;
            end
        end
    end

    assign busy = fr_busy || r_pending;

    clrs_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start && !r_pending),
        .i_back_ready(back_ready), .i_opcode(i_opcode), .i_char_code(i_char_code),
        .i_last_char(i_last_char), .i_number_value(i_number_value), .i_row(i_row),
        .i_column(i_column), .i_notify(i_notify), .o_busy(fr_busy),
        .o_req_valid(req_valid), .o_req(req)
    );

    clrs_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .MAX_DIGITS(MAX_DIGITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req_valid(req_valid), .i_req(req),
        .i_power_on_ticks(r_power_on_ticks), .o_ready(back_ready), .o_valid(o_valid),
        .o_status(o_status), .o_reg_select(o_reg_select), .o_read_write(o_read_write),
        .o_data_bus(o_data_bus), .o_enable(o_enable), .o_done_notice(o_done_notice),
        .o_init_done(o_init_done)
    );
endmodule
